// ===== rtl/sada_pkg.sv =====
// Shared types and constants for the slot allocator with a dense active set.
package sada_pkg;

    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE = 2'd2;

    typedef struct packed {
        logic capture;
        logic alloc_commit;
        logic free_lookup;
        logic free_commit;
    } sada_cmd_t;

endpackage

// ===== rtl/slot_allocator_dense_active_set_unit.sv =====
// Top level of the slot allocator with a LIFO reuse stack and a dense active set.
//
//   Channel   Handshake          Payload
//   request   start / busy       operation, slot_in
//   result    done (one cycle)   slot_out, status, active_count
//
// An allocate goes from transfer to result through a commit state, and a free through a lookup and then a
// commit state, around the registered reads of the reuse stack, back-position table and active list.
// busy is high from the cycle after a transfer until done is shown, and a new
// request can be transferred in the same cycle that done is high.
// rst_n clears the counters and the controller; the memories need no clearing pass.
// The receiver cannot stall: done stands for one cycle only.
module slot_allocator_dense_active_set_unit
    import sada_pkg::*;
#(
    parameter int POOL_SLOTS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                operation,
    input  logic [SLOT_W-1:0]   slot_in,
    output logic                done,
    output logic [SLOT_W-1:0]   slot_out,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  active_count
);

    sada_cmd_t cmd;

    sada_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .busy      (busy),
        .cmd       (cmd)
    );

    sada_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .slot_in      (slot_in),
        .done         (done),
        .slot_out     (slot_out),
        .status       (status),
        .active_count (active_count)
    );

endmodule

// ===== rtl/sada_ctrl.sv =====
// Controller state machine that sequences allocate and free requests.
module sada_ctrl
    import sada_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      operation,
    output logic      busy,
    output sada_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_ALLOC    = 2'd1;
    localparam logic [1:0] ST_FREE_CHK = 2'd2;
    localparam logic [1:0] ST_FREE_UPD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (operation == OP_FREE) ? ST_FREE_CHK : ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                cmd.alloc_commit = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_FREE_CHK:
            begin
                cmd.free_lookup = 1'b1;
                state_next      = ST_FREE_UPD;
            end
            ST_FREE_UPD:
            begin
                cmd.free_commit = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sada_dp.sv =====
// Datapath with the reuse stack, active list, back-position table and counters.
module sada_dp
    import sada_pkg::*;
#(
    parameter int POOL_SLOTS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sada_cmd_t           cmd,
    input  logic [SLOT_W-1:0]   slot_in,
    output logic                done,
    output logic [SLOT_W-1:0]   slot_out,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  active_count
);

    localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int OUT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CNT_W-1:0] POOL_COUNT = CNT_W'(POOL_SLOTS);

    logic [IDX_W-1:0] reuse_stack [POOL_SLOTS];
    logic [IDX_W-1:0] active_list [POOL_SLOTS];
    logic [IDX_W-1:0] back_pos    [POOL_SLOTS];

    logic [CNT_W-1:0] reuse_depth_reg, reuse_depth_next;
    logic [CNT_W-1:0] high_water_reg, high_water_next;
    logic [CNT_W-1:0] active_total_reg, active_total_next;

    logic [SLOT_W-1:0] slot_reg;
    logic [IDX_W-1:0]  rs_q;
    logic [IDX_W-1:0]  bp_q;
    logic [IDX_W-1:0]  al_q;
    logic [IDX_W-1:0]  last_reg;

    logic                done_reg;
    logic [SLOT_W-1:0]   slot_out_reg, slot_out_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    logic [CMP_W-1:0] slot_in_ext;
    logic [CMP_W-1:0] slot_reg_ext;
    logic [IDX_W-1:0] slot_in_idx;
    logic [IDX_W-1:0] slot_reg_idx;
    logic [CNT_W-1:0] total_minus_one;
    logic [CNT_W-1:0] depth_minus_one;
    logic [IDX_W-1:0] al_raddr;

    logic             have_reuse;
    logic             have_fresh;
    logic             alloc_ok;
    logic [IDX_W-1:0] alloc_slot;
    logic [CMP_W-1:0] alloc_slot_ext;
    logic             free_ok;
    logic [OUT_W-1:0] count_ext;

    logic             al_we;
    logic [IDX_W-1:0] al_waddr;
    logic [IDX_W-1:0] al_wdata;
    logic             bp_we;
    logic [IDX_W-1:0] bp_waddr;
    logic [IDX_W-1:0] bp_wdata;
    logic             rs_we;

    assign slot_in_ext     = CMP_W'(slot_in);
    assign slot_reg_ext    = CMP_W'(slot_reg);
    assign slot_in_idx     = slot_in_ext[IDX_W-1:0];
    assign slot_reg_idx    = slot_reg_ext[IDX_W-1:0];
    assign total_minus_one = active_total_reg - 1'b1;
    assign depth_minus_one = reuse_depth_reg - 1'b1;
    assign al_raddr        = cmd.capture ? total_minus_one[IDX_W-1:0] : bp_q;

    assign have_reuse     = (reuse_depth_reg != '0);
    assign have_fresh     = (high_water_reg != POOL_COUNT);
    assign alloc_ok       = have_reuse || have_fresh;
    assign alloc_slot     = have_reuse ? rs_q : high_water_reg[IDX_W-1:0];
    assign alloc_slot_ext = CMP_W'(alloc_slot);

    assign free_ok = (slot_reg_ext < CMP_W'(high_water_reg))
                  && (CNT_W'(bp_q) < active_total_reg)
                  && (al_q == slot_reg_idx);

    always_comb
    begin
        reuse_depth_next  = reuse_depth_reg;
        high_water_next   = high_water_reg;
        active_total_next = active_total_reg;
        slot_out_next     = slot_out_reg;
        status_next       = status_reg;
        al_we             = 1'b0;
        al_waddr          = active_total_reg[IDX_W-1:0];
        al_wdata          = alloc_slot;
        bp_we             = 1'b0;
        bp_waddr          = alloc_slot;
        bp_wdata          = active_total_reg[IDX_W-1:0];
        rs_we             = 1'b0;
        if (cmd.alloc_commit)
        begin
            if (alloc_ok)
            begin
                if (have_reuse)
                begin
                    reuse_depth_next = depth_minus_one;
                end
                else
                begin
                    high_water_next = high_water_reg + 1'b1;
                end
                al_we             = 1'b1;
                bp_we             = 1'b1;
                active_total_next = active_total_reg + 1'b1;
                slot_out_next     = alloc_slot_ext[SLOT_W-1:0];
                status_next       = STATUS_OK;
            end
            else
            begin
                slot_out_next = '0;
                status_next   = STATUS_FULL;
            end
        end
        else if (cmd.free_commit)
        begin
            slot_out_next = slot_reg;
            if (free_ok)
            begin
                rs_we             = 1'b1;
                reuse_depth_next  = reuse_depth_reg + 1'b1;
                al_we             = 1'b1;
                al_waddr          = bp_q;
                al_wdata          = last_reg;
                bp_we             = 1'b1;
                bp_waddr          = last_reg;
                bp_wdata          = bp_q;
                active_total_next = total_minus_one;
                status_next       = STATUS_OK;
            end
            else
            begin
                status_next = STATUS_NOT_IN_USE;
            end
        end
    end

    assign count_ext  = OUT_W'(active_total_next);
    assign count_next = count_ext[COUNT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            reuse_stack[reuse_depth_reg[IDX_W-1:0]] <= slot_reg_idx;
        end
        if (cmd.capture)
        begin
            rs_q <= reuse_stack[depth_minus_one[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (al_we)
        begin
            active_list[al_waddr] <= al_wdata;
        end
        if (cmd.capture || cmd.free_lookup)
        begin
            al_q <= active_list[al_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bp_we)
        begin
            back_pos[bp_waddr] <= bp_wdata;
        end
        if (cmd.capture)
        begin
            bp_q <= back_pos[slot_in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg <= slot_in;
        end
        if (cmd.free_lookup)
        begin
            last_reg <= al_q;
        end
        if (cmd.alloc_commit || cmd.free_commit)
        begin
            slot_out_reg <= slot_out_next;
            status_reg   <= status_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reuse_depth_reg  <= '0;
            high_water_reg   <= '0;
            active_total_reg <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            reuse_depth_reg  <= reuse_depth_next;
            high_water_reg   <= high_water_next;
            active_total_reg <= active_total_next;
            done_reg         <= cmd.alloc_commit || cmd.free_commit;
        end
    end

    assign done         = done_reg;
    assign slot_out     = slot_out_reg;
    assign status       = status_reg;
    assign active_count = count_reg;

endmodule

// ===== dv/slot_allocator_dense_active_set_unit_tb.sv =====
// Self-checking testbench for the slot allocator with a LIFO reuse stack and dense active set.
module slot_allocator_dense_active_set_unit_tb
    import sada_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SLOTS = 256;
    localparam int TARGET_REQUESTS = 950;

    typedef struct {
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } reply_t;

    class slot_pool_scoreboard;
        logic [SLOT_W-1:0] reuse_stack [POOL_SLOTS];
        logic [SLOT_W-1:0] active_list [POOL_SLOTS];
        int unsigned       back_pos [POOL_SLOTS];
        bit                live [POOL_SLOTS];
        int unsigned       reuse_depth;
        int unsigned       high_water;
        int unsigned       active_total;
        reply_t            replies_due [$];
        int unsigned       errors;

        function new();
            foreach (live[i])
            begin
                live[i] = 1'b0;
                back_pos[i] = 0;
            end
            reuse_depth = 0;
            high_water = 0;
            active_total = 0;
            errors = 0;
        endfunction

        function int unsigned in_use();
            return active_total;
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction

        function void queue_reply(reply_t r);
            replies_due.insert(replies_due.size(), r);
        endfunction

        function logic [SLOT_W-1:0] free_target();
            if (active_total > 0 && $urandom_range(0, 9) < 8)
                return active_list[$urandom_range(0, active_total - 1)];
            return SLOT_W'($urandom_range(0, 255));
        endfunction

        function void note_request(logic op, logic [SLOT_W-1:0] slot);
            reply_t      r;
            int unsigned pick;
            int unsigned pos;
            logic [SLOT_W-1:0] last_slot;
            if (op == OP_ALLOC)
            begin
                if (reuse_depth > 0)
                begin
                    reuse_depth--;
                    pick = reuse_stack[reuse_depth];
                end
                else if (high_water < POOL_SLOTS)
                begin
                    pick = high_water;
                    high_water++;
                end
                else
                begin
                    r.slot = '0;
                    r.status = STATUS_FULL;
                    r.count = COUNT_W'(active_total);
                    queue_reply(r);
                    return;
                end
                back_pos[pick] = active_total;
                live[pick] = 1'b1;
                active_list[active_total] = SLOT_W'(pick);
                active_total++;
                r.slot = SLOT_W'(pick);
                r.status = STATUS_OK;
            end
            else if (!live[slot])
            begin
                r.slot = slot;
                r.status = STATUS_NOT_IN_USE;
            end
            else
            begin
                reuse_stack[reuse_depth] = slot;
                reuse_depth++;
                pos = back_pos[slot];
                last_slot = active_list[active_total - 1];
                active_list[pos] = last_slot;
                back_pos[last_slot] = pos;
                live[slot] = 1'b0;
                back_pos[slot] = 0;
                active_total--;
                r.slot = slot;
                r.status = STATUS_OK;
            end
            r.count = COUNT_W'(active_total);
            queue_reply(r);
        endfunction

        function void check_result(logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] st,
                                   logic [COUNT_W-1:0] cnt);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: result with no request outstanding: slot_out %0d status %0d count %0d",
                         $time, slot, st, cnt);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (slot !== want.slot)
            begin
                $display("%0t: slot_out expected %0d actual %0d", $time, want.slot, slot);
                errors++;
            end
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                errors++;
            end
            if (cnt !== want.count)
            begin
                $display("%0t: active_count expected %0d actual %0d", $time, want.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                operation;
    logic [SLOT_W-1:0]   slot_in;
    logic                done;
    logic [SLOT_W-1:0]   slot_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  active_count;

    slot_pool_scoreboard sb;
    int unsigned         issued;
    int unsigned         burst_left;

    slot_allocator_dense_active_set_unit #(.POOL_SLOTS(POOL_SLOTS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .slot_in      (slot_in),
        .done         (done),
        .slot_out     (slot_out),
        .status       (status),
        .active_count (active_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(slot_out, status, active_count);
    end

    task automatic issue(input logic op, input logic [SLOT_W-1:0] slot);
        int gap;
        @(negedge clk);
        start = 1'b1;
        operation = op;
        slot_in = slot;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(op, slot);
        issued++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                start = 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic random_request(input int alloc_pct);
        if ($urandom_range(1, 100) <= alloc_pct)
            issue(OP_ALLOC, SLOT_W'($urandom_range(0, 255)));
        else
            issue(OP_FREE, sb.free_target());
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int round_len;
        int alloc_pct;
        int drain_wait;
        sb = new();
        issued = 0;
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_ALLOC;
        slot_in = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        issue(OP_ALLOC, 8'd0);
        issue(OP_ALLOC, 8'hff);
        issue(OP_ALLOC, 8'h5a);
        issue(OP_FREE, 8'd255);
        issue(OP_FREE, 8'd1);
        issue(OP_FREE, 8'd1);
        issue(OP_ALLOC, 8'd0);
        issue(OP_FREE, 8'd1);
        issue(OP_FREE, 8'd2);
        issue(OP_FREE, 8'd0);
        issue(OP_FREE, 8'd0);
        issue(OP_ALLOC, 8'd0);
        issue(OP_ALLOC, 8'd0);
        issue(OP_ALLOC, 8'd0);
        issue(OP_ALLOC, 8'd0);
        issue(OP_FREE, 8'haa);
        issue(OP_FREE, 8'h55);
        issue(OP_FREE, 8'd3);
        issue(OP_FREE, 8'd0);
        wait_quiet();

        // Fill the whole pool, then keep asking so that full is reported.
        while (sb.in_use() < POOL_SLOTS)
            random_request(90);
        repeat ($urandom_range(3, 8))
            issue(OP_ALLOC, SLOT_W'($urandom_range(0, 255)));
        wait_quiet();

        while (sb.in_use() > 0)
            random_request(15);
        repeat ($urandom_range(2, 5))
            issue(OP_FREE, SLOT_W'($urandom_range(0, 255)));
        wait_quiet();

        while (issued < TARGET_REQUESTS)
        begin
            round_len = $urandom_range(40, 150);
            if (round_len > int'(TARGET_REQUESTS - issued))
                round_len = int'(TARGET_REQUESTS - issued);
            alloc_pct = $urandom_range(20, 80);
            repeat (round_len)
                random_request(alloc_pct);
            if ($urandom_range(0, 1) == 0)
                wait_quiet();
        end

        @(negedge clk);
        start = 1'b0;
        drain_wait = 0;
        while (sb.pending() > 0 && drain_wait < 200)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (8)
            @(posedge clk);
        if (sb.pending() > 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
